FILE: hw/rtl/ipds_pkg.sv
package ipds_pkg;

	// Frame layout
	localparam int PAYLOAD_BYTES = 12;
	localparam int STORE_DEPTH   = PAYLOAD_BYTES - 1;
	localparam int CNT_W         = 4;
	localparam int PKT_W         = 8 * PAYLOAD_BYTES;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	// Arithmetic widths
	localparam int SAMPLE_W   = 16;
	localparam int SCALE_W    = 24;
	localparam int PROD_W     = SAMPLE_W + SCALE_W + 1;
	localparam int OUT_W      = 24;
	localparam int OUT_SHIFT  = 16;
	localparam int NUM_OUT    = 6;
	localparam int NUM_ACCEL  = 3;
	localparam int OUT_DATA_W = NUM_OUT * OUT_W;

	// Configuration registers
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_ACCEL_GAIN = 1'b0;
	localparam logic REG_GYRO_GAIN  = 1'b1;

	localparam logic [SCALE_W-1:0] ACCEL_GAIN_RST = 24'd2571633;
	localparam logic [SCALE_W-1:0] GYRO_GAIN_RST  = 24'd572224;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_SYNC2 = 2'd1,
		PH_DATA  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [SCALE_W-1:0] accel_gain;
		logic [SCALE_W-1:0] gyro_gain;
	} scale_cfg_t;

endpackage

FILE: hw/rtl/ipds_regs.sv
module ipds_regs import ipds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output scale_cfg_t            cfg
);

	logic [SCALE_W-1:0] accel_gain_q;
	logic [SCALE_W-1:0] gyro_gain_q;
	logic               wr_en;
	logic               reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	// Registers sit on word boundaries; the byte offset bits are ignored.
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_gain_q <= ACCEL_GAIN_RST;
			gyro_gain_q  <= GYRO_GAIN_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ACCEL_GAIN: accel_gain_q <= pwdata[SCALE_W-1:0];
				REG_GYRO_GAIN:  gyro_gain_q  <= pwdata[SCALE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ACCEL_GAIN: prdata = APB_DATA_W'(accel_gain_q);
			REG_GYRO_GAIN:  prdata = APB_DATA_W'(gyro_gain_q);
		endcase
	end

	assign cfg.accel_gain = accel_gain_q;
	assign cfg.gyro_gain  = gyro_gain_q;

endmodule

FILE: hw/rtl/ipds_framer.sv
module ipds_framer import ipds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_ready,
	input  logic [7:0]       rx_byte,
	input  logic             pkt_take,
	output logic             pkt_valid,
	output logic [PKT_W-1:0] pkt
);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0]       store_q [STORE_DEPTH];
	logic             store_we;
	logic             emit;
	logic             acc;
	logic [PKT_W-1:0] pkt_d;
	logic [PKT_W-1:0] pkt_s1;
	logic             valid_s1;

	// A finished packet waits here only until the scaler takes it.
	assign byte_ready = !valid_s1 || pkt_take;
	assign acc        = byte_valid && byte_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		store_we = 1'b0;
		emit     = 1'b0;
		if (acc) begin
			unique case (phase_q)
				PH_SYNC2: begin
					// A broken header drops back to hunting without retesting this word.
					if (rx_byte == SYNC_SECOND) begin
						phase_d = PH_DATA;
						count_d = '0;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_DATA: begin
					if (count_q < CNT_W'(STORE_DEPTH)) begin
						store_we = 1'b1;
						count_d  = count_q + 1'b1;
					end else begin
						emit    = 1'b1;
						phase_d = PH_HUNT;
						count_d = '0;
					end
				end
				default: begin
					phase_d = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
					count_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[count_q] <= rx_byte;
		end
	end

	always_comb begin
		for (int k = 0; k < STORE_DEPTH; k++) begin
			pkt_d[8*k +: 8] = store_q[k];
		end
		pkt_d[8*STORE_DEPTH +: 8] = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			valid_s1 <= 1'b1;
		end else if (pkt_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pkt_s1 <= pkt_d;
		end
	end

	assign pkt_valid = valid_s1;
	assign pkt       = pkt_s1;

endmodule

FILE: hw/rtl/ipds_scaler.sv
module ipds_scaler import ipds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scale_cfg_t            cfg,
	input  logic                  pkt_valid,
	input  logic [PKT_W-1:0]      pkt,
	output logic                  pkt_take,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic [OUT_DATA_W-1:0] res_d;
	logic [OUT_DATA_W-1:0] res_s2;
	logic                  valid_s2;

	assign pkt_take = !valid_s2 || out_ready;

	for (genvar k = 0; k < NUM_OUT; k++) begin : g_lane
		logic signed [SAMPLE_W-1:0] sample;
		logic        [SCALE_W-1:0]  scale;
		logic signed [PROD_W-1:0]   prod;

		// Samples arrive high byte first.
		assign sample = {pkt[16*k +: 8], pkt[16*k+8 +: 8]};
		assign scale  = (k < NUM_ACCEL) ? cfg.accel_gain : cfg.gyro_gain;
		assign prod   = sample * $signed({1'b0, scale});
		// Dropping the low bits of a two's complement product floors it.
		assign res_d[OUT_W*k +: OUT_W] = prod[OUT_SHIFT +: OUT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pkt_take) begin
			valid_s2 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take && pkt_valid) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

FILE: hw/rtl/imu_packet_deframer_scaler_top.sv
// The framer registers the packet that the last payload byte completes; the scaler
// then registers its result word. Throughput: one byte per cycle unless input stalls;
// two header and twelve payload bytes yield one result word of six products.
// A result waiting at the output does not stall input until a second frame completes.
// Reset (arst_n low, asynchronous) returns the framer to hunting, empties both
// stages and loads the default scales.
module imu_packet_deframer_scaler_top import ipds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [23:0] accel_x, [47:24] accel_y, [71:48] accel_z,
	// [95:72] rate_x, [119:96] rate_y, [143:120] rate_z
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	scale_cfg_t       cfg;
	logic             pkt_valid;
	logic             pkt_take;
	logic [PKT_W-1:0] pkt;

	ipds_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipds_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_ready (s_axis_tready),
		.rx_byte    (s_axis_tdata),
		.pkt_take   (pkt_take),
		.pkt_valid  (pkt_valid),
		.pkt        (pkt)
	);

	ipds_scaler u_scaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.pkt_take  (pkt_take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: hw/rtl/ipds_checker.sv
module ipds_checker import ipds_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata,
	input logic                  pready
);

	logic in_acc;
	logic cfg_wr;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_wr = psel && penable && pwrite && pready;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// Input only stalls when a finished result is blocked at the output.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a blocked output");

	// A new result is registered after the byte that completed its frame is taken.
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_acc, 2))
		else $error("result word without a completing byte");

	// A written accel scale reads back with the upper bits clear.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && paddr[2] == REG_ACCEL_GAIN ##1 psel && !pwrite && paddr[2] == REG_ACCEL_GAIN
		|-> prdata == {8'h00, $past(pwdata[SCALE_W-1:0])})
		else $error("scale register read back mismatch");

endmodule

bind imu_packet_deframer_scaler_top ipds_checker u_ipds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata),
	.pready        (pready)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

import ipds_pkg::*;

class imu_frame_scoreboard;
	logic [SCALE_W-1:0]    accel_gain;
	logic [SCALE_W-1:0]    gyro_gain;
	phase_t                framer_phase;
	int unsigned           byte_count;
	logic [7:0]            frame_bytes[STORE_DEPTH];
	logic [OUT_DATA_W-1:0] frame_queue[$];
	int                    errors;

	function new();
		accel_gain   = ACCEL_GAIN_RST;
		gyro_gain    = GYRO_GAIN_RST;
		framer_phase = PH_HUNT;
		byte_count   = 0;
		errors       = 0;
	endfunction

	function void set_gain(logic reg_sel, logic [APB_DATA_W-1:0] value);
		if (reg_sel == REG_ACCEL_GAIN) begin
			accel_gain = value[SCALE_W-1:0];
		end else begin
			gyro_gain = value[SCALE_W-1:0];
		end
	endfunction

	// Signed sample times unsigned gain, then floor division by 2^16.
	function logic [OUT_W-1:0] scaled(logic [SAMPLE_W-1:0] raw, logic [SCALE_W-1:0] gain);
		longint      prod;
		logic [63:0] shifted;
		prod    = longint'($signed(raw)) * longint'(gain);
		shifted = prod >>> OUT_SHIFT;
		return shifted[OUT_W-1:0];
	endfunction

	function void note_byte(logic [7:0] rx);
		logic [7:0]            frame[PAYLOAD_BYTES];
		logic [OUT_DATA_W-1:0] result;
		case (framer_phase)
			PH_SYNC2: begin
				if (rx == SYNC_SECOND) begin
					framer_phase = PH_DATA;
					byte_count   = 0;
				end else begin
					framer_phase = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (byte_count < STORE_DEPTH) begin
					frame_bytes[byte_count] = rx;
					byte_count++;
				end else begin
					for (int i = 0; i < STORE_DEPTH; i++)
						frame[i] = frame_bytes[i];
					frame[STORE_DEPTH] = rx;
					for (int k = 0; k < NUM_OUT; k++)
						result[k*OUT_W +: OUT_W] = scaled({frame[2*k], frame[2*k+1]},
							(k < NUM_ACCEL) ? accel_gain : gyro_gain);
					frame_queue = {frame_queue, result};
					framer_phase = PH_HUNT;
					byte_count   = 0;
				end
			end
			default: begin
				// The unused phase code behaves like hunting.
				framer_phase = (rx == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
				byte_count   = 0;
			end
		endcase
	endfunction

	function void check_frame(logic [OUT_DATA_W-1:0] got);
		logic [OUT_DATA_W-1:0] want;
		string                 field_name[NUM_OUT];
		field_name = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y", "rate_z"};
		if (frame_queue.size() == 0) begin
			$error("result word with nothing expected: %h", got);
			errors++;
			return;
		end
		want = frame_queue.pop_front();
		for (int k = 0; k < NUM_OUT; k++) begin
			if (got[k*OUT_W +: OUT_W] !== want[k*OUT_W +: OUT_W]) begin
				$error("%s: expected %0d, got %0d", field_name[k],
					$signed(want[k*OUT_W +: OUT_W]), $signed(got[k*OUT_W +: OUT_W]));
				errors++;
			end
		end
	endfunction

	function int pending();
		return frame_queue.size();
	endfunction
endclass

module tb;
	localparam int MAX_GAP        = 18;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int NUM_PHASES     = 8;
	localparam int TAIL_CYCLES    = 8;

	// Broken header (the second 0xAA is not taken as a new header), then a frame
	// whose payload repeats header bytes and carries the extreme sample values.
	localparam logic [7:0] DIRECTED_BYTES[17] = '{
		SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
		SYNC_FIRST, SYNC_SECOND,
		SYNC_FIRST, SYNC_SECOND, SYNC_FIRST, SYNC_SECOND,
		8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [APB_ADDR_W-1:0] paddr         = '0;
	logic [APB_DATA_W-1:0] pwdata        = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	imu_frame_scoreboard sb;
	int                  cfg_errors  = 0;
	int                  frame_items = 0;
	int                  cycle_count = 0;
	bit                  tx_steady   = 1'b0;
	bit                  rx_steady   = 1'b0;

	imu_packet_deframer_scaler_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] value);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(value);
	endtask

	task automatic send_frame();
		logic [SAMPLE_W-1:0] sample;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		for (int k = 0; k < NUM_OUT; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0:       sample = 16'h8000;
					1:       sample = 16'h7FFF;
					2:       sample = 16'h0000;
					default: sample = 16'hFFFF;
				endcase
			end else begin
				sample = 16'($urandom);
			end
			send_byte(sample[15:8]);
			send_byte(sample[7:0]);
		end
		frame_items += 2 + PAYLOAD_BYTES;
	endtask

	// Mostly complete frames; the rest is line noise and headers cut short.
	task automatic run_traffic(input int n);
		int         start;
		logic [7:0] junk;
		start = frame_items;
		while (frame_items - start < n) begin
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
				1: begin
					junk = 8'($urandom);
					if (junk == SYNC_SECOND)
						junk = SYNC_FIRST;
					send_byte(SYNC_FIRST);
					send_byte(junk);
				end
				default: send_frame();
			endcase
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic program_scale(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
		logic [APB_ADDR_W-1:0] addr;
		logic [APB_DATA_W-1:0] want;
		addr = {reg_sel, 2'b00};
		want = APB_DATA_W'(value[SCALE_W-1:0]);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_gain(reg_sel, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("%s readback: expected %h, got %h",
				(reg_sel == REG_ACCEL_GAIN) ? "accel_gain" : "gyro_gain", want, prdata);
			cfg_errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : rx_side
		int gap;
		int results_seen;
		results_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				rx_steady = !rx_steady;
			gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			// Long hold-offs let frames pile up until the input side stalls.
			if (results_seen == 5 || results_seen == 40)
				gap = HOLDOFF_CYCLES;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_frame(m_axis_tdata);
			results_seen++;
		end
	end

	initial begin : tx_side
		logic [APB_DATA_W-1:0] accel_word;
		logic [APB_DATA_W-1:0] gyro_word;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_BYTES[i])
			send_byte(DIRECTED_BYTES[i]);
		run_traffic(RANDOM_ITEMS / NUM_PHASES);
		drain();
		for (int phase = 1; phase < NUM_PHASES; phase++) begin
			accel_word = $urandom;
			gyro_word  = $urandom;
			case (phase)
				1: begin
					accel_word[SCALE_W-1:0] = '1;
					gyro_word[SCALE_W-1:0]  = '1;
				end
				2: begin
					accel_word[SCALE_W-1:0] = '0;
					gyro_word[SCALE_W-1:0]  = '0;
				end
				3: begin
					accel_word[SCALE_W-1:0] = '1;
					gyro_word[SCALE_W-1:0]  = 24'd1;
				end
				4: begin
					accel_word[SCALE_W-1:0] = 24'd1;
					gyro_word[SCALE_W-1:0]  = '1;
				end
				default: ;
			endcase
			program_scale(REG_ACCEL_GAIN, accel_word);
			program_scale(REG_GYRO_GAIN, gyro_word);
			run_traffic(RANDOM_ITEMS / NUM_PHASES);
			drain();
		end
		if (sb.errors == 0 && cfg_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
